@@ rtl/core/rwct_pkg.sv @@
// rwct_pkg: shared constants and codes of the raster/world coordinate transform
// used by rwct_scale, rwct_rotate and raster_world_coordinate_transform
package rwct_pkg;

    localparam int FRACTION_BITS   = 16;
    localparam int COORDINATE_BITS = 48;
    localparam int SCALE_BITS      = 32;
    localparam int TRIG_BITS       = 18;
    localparam int FUNC_BITS       = 2;
    localparam int REG_INDEX_BITS  = 3;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_TO_WORLD = 2'd0,
        FUNC_TO_GRID  = 2'd1,
        FUNC_TO_CELL  = 2'd2,
        FUNC_QUADRANT = 2'd3
    } rwct_func_t;

    typedef enum logic [1:0] {
        QUAD_NW = 2'd0,
        QUAD_NE = 2'd1,
        QUAD_SE = 2'd2,
        QUAD_SW = 2'd3
    } rwct_quad_t;

    typedef enum logic [REG_INDEX_BITS-1:0] {
        REG_CELL_SIZE        = 3'd0,
        REG_INVERSE_CELL     = 3'd1,
        REG_LEFT_EDGE        = 3'd2,
        REG_TOP_EDGE         = 3'd3,
        REG_ROTATION_COSINE  = 3'd4,
        REG_ROTATION_SINE    = 3'd5,
        REG_Y_GROWS_DOWNWARD = 3'd6
    } rwct_reg_t;

endpackage

@@ rtl/core/rwct_scale.sv @@
// rwct_scale: two-lane pipelined multiply of signed coordinates by an unsigned
// fixed point factor, shift and saturate; depends on rwct_pkg
module rwct_scale #(
    parameter int COORDINATE_BITS = rwct_pkg::COORDINATE_BITS,
    parameter int FRACTION_BITS   = rwct_pkg::FRACTION_BITS
) (
    input  logic                                     clk,
    input  logic                                     load_product,
    input  logic                                     load_sum,
    input  logic        [rwct_pkg::SCALE_BITS-1:0]   factor,
    input  logic signed [COORDINATE_BITS-1:0]        first_in,
    input  logic signed [COORDINATE_BITS-1:0]        second_in,
    output logic signed [COORDINATE_BITS-1:0]        first_out,
    output logic signed [COORDINATE_BITS-1:0]        second_out
);

    localparam int C    = COORDINATE_BITS;
    localparam int F    = FRACTION_BITS;
    localparam int S    = rwct_pkg::SCALE_BITS;
    localparam int LO_W = C / 2;
    localparam int HI_W = C - LO_W;
    localparam int PW   = C + S + 1;
    localparam logic signed [PW-1:0] SAT_MAX = {{(PW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_MIN = {{(PW-C+1){1'b1}}, {(C-1){1'b0}}};

    function automatic logic signed [C-1:0] sat_coord(input logic signed [PW-1:0] v);
        logic signed [C-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[C-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[C-1:0];
        end
        else
        begin
            r = v[C-1:0];
        end
        return r;
    endfunction

    logic signed [C-1:0]        lane_in [2];
    logic        [LO_W+S-1:0]   lo_prod_next [2];
    logic signed [HI_W+S:0]     hi_prod_next [2];
    logic        [LO_W+S-1:0]   lo_prod_reg [2];
    logic signed [HI_W+S:0]     hi_prod_reg [2];
    logic signed [C-1:0]        result_next [2];
    logic signed [C-1:0]        result_reg [2];
    logic signed [PW-1:0]       full_prod [2];
    logic signed [PW-1:0]       shifted [2];

    assign lane_in[0] = first_in;
    assign lane_in[1] = second_in;

    // low half unsigned, high half signed: two partial products per lane
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            lo_prod_next[k] = {{S{1'b0}}, lane_in[k][LO_W-1:0]}
                            * {{LO_W{1'b0}}, factor};
            hi_prod_next[k] = $signed({{(S+1){lane_in[k][C-1]}}, lane_in[k][C-1:LO_W]})
                            * $signed({{HI_W{1'b0}}, 1'b0, factor});
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_product)
        begin
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            full_prod[k] = $signed({hi_prod_reg[k], {LO_W{1'b0}}})
                         + $signed({{(HI_W+1){1'b0}}, lo_prod_reg[k]});
            shifted[k]   = full_prod[k] >>> F;
            result_next[k] = sat_coord(shifted[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_sum)
        begin
            result_reg <= result_next;
        end
    end

    assign first_out  = result_reg[0];
    assign second_out = result_reg[1];

endmodule

@@ rtl/core/rwct_rotate.sv @@
// rwct_rotate: pipelined rotation of a coordinate pair by a cosine/sine pair,
// p = u*cos + v*sin and q = v*cos - u*sin, saturated; depends on rwct_pkg
module rwct_rotate #(
    parameter int COORDINATE_BITS = rwct_pkg::COORDINATE_BITS,
    parameter int FRACTION_BITS   = rwct_pkg::FRACTION_BITS
) (
    input  logic                                     clk,
    input  logic                                     load_product,
    input  logic                                     load_sum,
    input  logic signed [rwct_pkg::TRIG_BITS-1:0]    cosine,
    input  logic signed [rwct_pkg::TRIG_BITS-1:0]    sine,
    input  logic signed [COORDINATE_BITS-1:0]        u_in,
    input  logic signed [COORDINATE_BITS-1:0]        v_in,
    output logic signed [COORDINATE_BITS-1:0]        p_out,
    output logic signed [COORDINATE_BITS-1:0]        q_out
);

    localparam int C  = COORDINATE_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int TB = rwct_pkg::TRIG_BITS;
    localparam int PW = C + TB;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] SAT_MAX = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {{(SW-C+1){1'b1}}, {(C-1){1'b0}}};

    function automatic logic signed [C-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic signed [C-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[C-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[C-1:0];
        end
        else
        begin
            r = v[C-1:0];
        end
        return r;
    endfunction

    logic signed [PW-1:0] u_ext, v_ext, cos_ext, sin_ext;
    logic signed [PW-1:0] uc_reg, vs_reg, vc_reg, us_reg;
    logic signed [SW-1:0] p_sum, q_sum;
    logic signed [C-1:0]  p_reg, q_reg;

    assign u_ext   = {{TB{u_in[C-1]}}, u_in};
    assign v_ext   = {{TB{v_in[C-1]}}, v_in};
    assign cos_ext = {{C{cosine[TB-1]}}, cosine};
    assign sin_ext = {{C{sine[TB-1]}}, sine};

    always_ff @(posedge clk)
    begin
        if (load_product)
        begin
            uc_reg <= u_ext * cos_ext;
            vs_reg <= v_ext * sin_ext;
            vc_reg <= v_ext * cos_ext;
            us_reg <= u_ext * sin_ext;
        end
    end

    assign p_sum = {uc_reg[PW-1], uc_reg} + {vs_reg[PW-1], vs_reg};
    assign q_sum = {vc_reg[PW-1], vc_reg} - {us_reg[PW-1], us_reg};

    always_ff @(posedge clk)
    begin
        if (load_sum)
        begin
            p_reg <= sat_coord(p_sum >>> F);
            q_reg <= sat_coord(q_sum >>> F);
        end
    end

    assign p_out = p_reg;
    assign q_out = q_reg;

endmodule

@@ rtl/core/raster_world_coordinate_transform.sv @@
// raster_world_coordinate_transform: top level, stream ports, configuration
// registers and the twelve-stage pipeline; depends on rwct_pkg, rwct_scale, rwct_rotate

// Converts fractional raster row/column to world coordinates and back for a rotated,
// scaled and offset grid, in signed fixed point with FRACTION_BITS fraction bits.
// tuser selects the conversion: 0 row/col to world, 1 world to fractional row/col,
// 2 world to integer cell index (negative clamped to 0 and flagged), 3 quadrant of
// the point within its cell. Every item runs through the same twelve register
// stages (world to grid: offset, scale, rotate; cell center; grid to world: scale,
// rotate, offset; result select), and one item is taken every cycle while the
// output is drained. A stall at the output holds every full stage behind it;
// bubbles are squeezed out. Configuration writes are taken at any time but must
// only be made while no item is in flight.
module raster_world_coordinate_transform #(
    parameter int COORDINATE_BITS = rwct_pkg::COORDINATE_BITS,
    parameter int FRACTION_BITS   = rwct_pkg::FRACTION_BITS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // first_value, second_value
    input  logic [((2*COORDINATE_BITS+7)/8)*8-1:0]     s_tdata,
    // func
    input  logic [rwct_pkg::FUNC_BITS-1:0]             s_tuser,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // first_result, second_result, cell_quadrant, index_clamped
    output logic [((2*COORDINATE_BITS+3+7)/8)*8-1:0]   m_tdata,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [rwct_pkg::REG_INDEX_BITS-1:0]        cfg_index,
    input  logic [COORDINATE_BITS-1:0]                 cfg_data
);

    localparam int C          = COORDINATE_BITS;
    localparam int F          = FRACTION_BITS;
    localparam int S          = rwct_pkg::SCALE_BITS;
    localparam int TB         = rwct_pkg::TRIG_BITS;
    localparam int OUT_W      = ((2*C+3+7)/8)*8;
    localparam int STAGES     = 12;
    localparam int ST_DIFF    = 0;
    localparam int ST_G_PROD  = 1;
    localparam int ST_G_SUM   = 2;
    localparam int ST_GR_PROD = 3;
    localparam int ST_GR_SUM  = 4;
    localparam int ST_PREP    = 5;
    localparam int ST_W_PROD  = 6;
    localparam int ST_W_SUM   = 7;
    localparam int ST_WR_PROD = 8;
    localparam int ST_WR_SUM  = 9;
    localparam int ST_EDGE    = 10;
    localparam int ST_OUT     = 11;
    localparam logic [S-1:0]  SCALE_ONE = S'(64'd1 << F);
    localparam logic [TB-1:0] TRIG_ONE  = TB'(64'd1 << F);
    localparam logic signed [C:0] SAT_MAX = {2'b00, {(C-1){1'b1}}};
    localparam logic signed [C:0] SAT_MIN = {2'b11, {(C-1){1'b0}}};

    function automatic logic signed [C-1:0] sat_coord(input logic signed [C:0] v);
        logic signed [C-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[C-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[C-1:0];
        end
        else
        begin
            r = v[C-1:0];
        end
        return r;
    endfunction

    // configuration registers
    logic        [S-1:0]  cell_size_reg;
    logic        [S-1:0]  inverse_cell_size_reg;
    logic signed [C-1:0]  left_edge_reg;
    logic signed [C-1:0]  top_edge_reg;
    logic signed [TB-1:0] rotation_cosine_reg;
    logic signed [TB-1:0] rotation_sine_reg;
    logic                 y_grows_downward_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg         <= SCALE_ONE;
            inverse_cell_size_reg <= SCALE_ONE;
            left_edge_reg         <= '0;
            top_edge_reg          <= '0;
            rotation_cosine_reg   <= TRIG_ONE;
            rotation_sine_reg     <= '0;
            y_grows_downward_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (rwct_pkg::rwct_reg_t'(cfg_index))
                rwct_pkg::REG_CELL_SIZE:        cell_size_reg         <= cfg_data[S-1:0];
                rwct_pkg::REG_INVERSE_CELL:     inverse_cell_size_reg <= cfg_data[S-1:0];
                rwct_pkg::REG_LEFT_EDGE:        left_edge_reg         <= cfg_data;
                rwct_pkg::REG_TOP_EDGE:         top_edge_reg          <= cfg_data;
                rwct_pkg::REG_ROTATION_COSINE:  rotation_cosine_reg   <= cfg_data[TB-1:0];
                rwct_pkg::REG_ROTATION_SINE:    rotation_sine_reg     <= cfg_data[TB-1:0];
                rwct_pkg::REG_Y_GROWS_DOWNWARD: y_grows_downward_reg  <= cfg_data[0];
                default:                        ;
            endcase
        end
    end

    // pipeline control: a stage loads when it is empty or its successor loads
    logic [STAGES-1:0] valid_reg, valid_next, valid_in;
    logic [STAGES:0]   rdy;

    always_comb
    begin
        rdy[STAGES] = m_tready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign valid_in = {valid_reg[STAGES-2:0], s_tvalid};

    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            valid_next[i] = rdy[i] ? valid_in[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[ST_OUT];

    // input fields
    rwct_pkg::rwct_func_t in_func;
    logic signed [C-1:0]  in_first, in_second;

    assign in_func   = rwct_pkg::rwct_func_t'(s_tuser);
    assign in_first  = s_tdata[C-1:0];
    assign in_second = s_tdata[2*C-1:C];

    // side data carried along the stages
    rwct_pkg::rwct_func_t func_reg [0:ST_OUT];
    logic signed [C-1:0]  a_reg [0:ST_EDGE];
    logic signed [C-1:0]  b_reg [0:ST_EDGE];

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            func_reg[0] <= in_func;
            a_reg[0]    <= in_first;
            b_reg[0]    <= in_second;
        end
        for (int i = 1; i <= ST_OUT; i++)
        begin
            if (rdy[i])
            begin
                func_reg[i] <= func_reg[i-1];
            end
        end
        for (int i = 1; i <= ST_EDGE; i++)
        begin
            if (rdy[i])
            begin
                a_reg[i] <= a_reg[i-1];
                b_reg[i] <= b_reg[i-1];
            end
        end
    end

    // stage 0: offsets from the upper left corner
    logic signed [C:0]   dx_wide, dy_wide;
    logic signed [C-1:0] dx_reg, dy_reg;

    always_comb
    begin
        dx_wide = {in_first[C-1], in_first} - {left_edge_reg[C-1], left_edge_reg};
        if (y_grows_downward_reg)
        begin
            dy_wide = {in_second[C-1], in_second} - {top_edge_reg[C-1], top_edge_reg};
        end
        else
        begin
            dy_wide = {top_edge_reg[C-1], top_edge_reg} - {in_second[C-1], in_second};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_DIFF])
        begin
            dx_reg <= sat_coord(dx_wide);
            dy_reg <= sat_coord(dy_wide);
        end
    end

    // stages 1 to 4: world to grid
    logic signed [C-1:0] xc, yc, grid_col, grid_row;

    rwct_scale #(
        .COORDINATE_BITS (C),
        .FRACTION_BITS   (F)
    ) u_scale_grid (
        .clk          (clk),
        .load_product (rdy[ST_G_PROD]),
        .load_sum     (rdy[ST_G_SUM]),
        .factor       (inverse_cell_size_reg),
        .first_in     (dx_reg),
        .second_in    (dy_reg),
        .first_out    (xc),
        .second_out   (yc)
    );

    rwct_rotate #(
        .COORDINATE_BITS (C),
        .FRACTION_BITS   (F)
    ) u_rotate_grid (
        .clk          (clk),
        .load_product (rdy[ST_GR_PROD]),
        .load_sum     (rdy[ST_GR_SUM]),
        .cosine       (rotation_cosine_reg),
        .sine         (rotation_sine_reg),
        .u_in         (xc),
        .v_in         (yc),
        .p_out        (grid_col),
        .q_out        (grid_row)
    );

    // stage 5: grid results and inputs of the world transform
    logic signed [C-1:0] row_center, col_center;
    logic signed [C-1:0] row_index, col_index;
    logic signed [C-1:0] w_row_next, w_col_next, res1_next, res2_next;
    logic                clamp_next;
    logic signed [C-1:0] w_row_reg, w_col_reg;
    logic signed [C-1:0] res1_reg [ST_PREP:ST_EDGE];
    logic signed [C-1:0] res2_reg [ST_PREP:ST_EDGE];
    logic                clamp_reg [ST_PREP:ST_EDGE];

    // floor plus one half never overflows
    assign row_center = {grid_row[C-1:F], 1'b1, {(F-1){1'b0}}};
    assign col_center = {grid_col[C-1:F], 1'b1, {(F-1){1'b0}}};
    assign row_index  = grid_row[C-1] ? '0 : {{F{1'b0}}, grid_row[C-1:F]};
    assign col_index  = grid_col[C-1] ? '0 : {{F{1'b0}}, grid_col[C-1:F]};

    always_comb
    begin
        w_row_next = row_center;
        w_col_next = col_center;
        res1_next  = '0;
        res2_next  = '0;
        clamp_next = 1'b0;
        case (func_reg[ST_GR_SUM])
            rwct_pkg::FUNC_TO_WORLD:
            begin
                w_row_next = a_reg[ST_GR_SUM];
                w_col_next = b_reg[ST_GR_SUM];
            end
            rwct_pkg::FUNC_TO_GRID:
            begin
                res1_next = grid_row;
                res2_next = grid_col;
            end
            rwct_pkg::FUNC_TO_CELL:
            begin
                res1_next  = row_index;
                res2_next  = col_index;
                clamp_next = grid_row[C-1] || grid_col[C-1];
            end
            default:
            begin
                res1_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_PREP])
        begin
            w_row_reg          <= w_row_next;
            w_col_reg          <= w_col_next;
            res1_reg[ST_PREP]  <= res1_next;
            res2_reg[ST_PREP]  <= res2_next;
            clamp_reg[ST_PREP] <= clamp_next;
        end
        for (int i = ST_PREP + 1; i <= ST_EDGE; i++)
        begin
            if (rdy[i])
            begin
                res1_reg[i]  <= res1_reg[i-1];
                res2_reg[i]  <= res2_reg[i-1];
                clamp_reg[i] <= clamp_reg[i-1];
            end
        end
    end

    // stages 6 to 9: grid to world
    logic signed [C-1:0] yr, xr, yt, xt;

    rwct_scale #(
        .COORDINATE_BITS (C),
        .FRACTION_BITS   (F)
    ) u_scale_world (
        .clk          (clk),
        .load_product (rdy[ST_W_PROD]),
        .load_sum     (rdy[ST_W_SUM]),
        .factor       (cell_size_reg),
        .first_in     (w_row_reg),
        .second_in    (w_col_reg),
        .first_out    (yr),
        .second_out   (xr)
    );

    rwct_rotate #(
        .COORDINATE_BITS (C),
        .FRACTION_BITS   (F)
    ) u_rotate_world (
        .clk          (clk),
        .load_product (rdy[ST_WR_PROD]),
        .load_sum     (rdy[ST_WR_SUM]),
        .cosine       (rotation_cosine_reg),
        .sine         (rotation_sine_reg),
        .u_in         (yr),
        .v_in         (xr),
        .p_out        (yt),
        .q_out        (xt)
    );

    // stage 10: back to world offsets
    logic signed [C:0]   wx_wide, wy_wide;
    logic signed [C-1:0] wx_reg, wy_reg;

    always_comb
    begin
        wx_wide = {left_edge_reg[C-1], left_edge_reg} + {xt[C-1], xt};
        if (y_grows_downward_reg)
        begin
            wy_wide = {top_edge_reg[C-1], top_edge_reg} + {yt[C-1], yt};
        end
        else
        begin
            wy_wide = {top_edge_reg[C-1], top_edge_reg} - {yt[C-1], yt};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_EDGE])
        begin
            wx_reg <= sat_coord(wx_wide);
            wy_reg <= sat_coord(wy_wide);
        end
    end

    // stage 11: result select, output register
    logic                 west, north;
    rwct_pkg::rwct_quad_t quad_calc;
    logic signed [C-1:0]  out1_next, out2_next;
    rwct_pkg::rwct_quad_t quad_next;
    logic signed [C-1:0]  out1_reg, out2_reg;
    rwct_pkg::rwct_quad_t quad_reg;
    logic                 out_clamp_reg;

    assign west  = a_reg[ST_EDGE] < wx_reg;
    assign north = y_grows_downward_reg ? (b_reg[ST_EDGE] < wy_reg)
                                        : (b_reg[ST_EDGE] > wy_reg);

    always_comb
    begin
        if (north)
        begin
            quad_calc = west ? rwct_pkg::QUAD_NW : rwct_pkg::QUAD_NE;
        end
        else
        begin
            quad_calc = west ? rwct_pkg::QUAD_SW : rwct_pkg::QUAD_SE;
        end
    end

    always_comb
    begin
        out1_next = res1_reg[ST_EDGE];
        out2_next = res2_reg[ST_EDGE];
        quad_next = rwct_pkg::QUAD_NW;
        case (func_reg[ST_EDGE])
            rwct_pkg::FUNC_TO_WORLD:
            begin
                out1_next = wx_reg;
                out2_next = wy_reg;
            end
            rwct_pkg::FUNC_QUADRANT:
            begin
                out1_next = '0;
                out2_next = '0;
                quad_next = quad_calc;
            end
            default:
            begin
                quad_next = rwct_pkg::QUAD_NW;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_OUT])
        begin
            out1_reg      <= out1_next;
            out2_reg      <= out2_next;
            quad_reg      <= quad_next;
            out_clamp_reg <= clamp_reg[ST_EDGE];
        end
    end

    assign m_tdata = {{(OUT_W-2*C-3){1'b0}}, out_clamp_reg, quad_reg, out2_reg, out1_reg};

`ifndef SYNTHESIS
    a_clamp_only_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_OUT] && out_clamp_reg) |-> func_reg[ST_OUT] == rwct_pkg::FUNC_TO_CELL)
        else $error("index clamp flag set on a non-cell item");

    a_quad_only_quadrant: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_OUT] && quad_reg != rwct_pkg::QUAD_NW)
        |-> func_reg[ST_OUT] == rwct_pkg::FUNC_QUADRANT)
        else $error("quadrant set on a non-quadrant item");

    a_quadrant_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_OUT] && func_reg[ST_OUT] == rwct_pkg::FUNC_QUADRANT)
        |-> (out1_reg == '0 && out2_reg == '0))
        else $error("quadrant item carries coordinates");

    a_cell_index_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_OUT] && func_reg[ST_OUT] == rwct_pkg::FUNC_TO_CELL)
        |-> (!out1_reg[C-1] && !out2_reg[C-1]))
        else $error("negative cell index");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_EDGE] && !rdy[ST_OUT]) |=> valid_reg[ST_EDGE])
        else $error("item lost in a stalled stage");
`endif

endmodule
